// ----- rtl/two_ended_tail_placer_macros.svh -----
// Assertion macros shared by the tail placer RTL.
// Needs a clock named i_clk and a reset named i_rst_n in the including scope.
`ifndef TWO_ENDED_TAIL_PLACER_MACROS_SVH
`define TWO_ENDED_TAIL_PLACER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TEP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define TEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tep_pkg.sv -----
// Shared constants for the two-ended tail placer.
// No dependencies.
package tep_pkg;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SIZE = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_SEG     = 2'd1;
    localparam logic [1:0] REG_REGION  = 2'd2;
    localparam logic [1:0] REG_LOGICAL = 2'd3;

    localparam logic [12:0] SEG_MAX = 13'd4096;

    typedef logic [12:0] t_size;
endpackage

// ----- rtl/tep_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tep_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                  i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/tep_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module tep_div #(
    parameter int DW = 48,
    parameter int SW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [SW-1:0] o_rem
);
    localparam int CNW = $clog2(DW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_q;
    logic [SW-1:0]  r_r;
    logic [SW-1:0]  r_d;
    logic [SW:0]    trial;
    logic [SW:0]    diff;
    logic           take;

    assign trial = {r_r, r_q[DW-1]};
    assign take  = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], take};
            r_r <= take ? diff[SW-1:0] : trial[SW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// ----- rtl/two_ended_tail_placer.sv -----
// Two-ended tail placer top level: APB registers, sequencer, segment table.
// Depends on tep_pkg, tep_ram, tep_div and two_ended_tail_placer_macros.svh.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-------------------------------------
//  input    | i_in_valid   | o_in_ready   | i_stored_size, i_restart
//  result   | o_out_valid  | i_out_ready  | o_block_number .. o_table_overflow
//  config   | psel&penable | pready (=1)  | paddr, pwdata, pwrite / prdata
//
// One item at a time. An item runs through up to six divisions on the shared
// divider (restart, size split, chunk align, tail align, two regions) and,
// when it has a tail, one pass over the segment table RAM; blocks without a
// restart, a tail, full chunks or a new segment skip the matching steps.
// Reset is synchronous; all segment slots come out closed, so table RAM needs
// no clearing. A stalled result holds in the output register while the next
// item is already taken and worked on.
`include "two_ended_tail_placer_macros.svh"
module two_ended_tail_placer #(
    parameter int MAX_OPEN_SEGMENTS = 64,
    parameter int ADDRESS_BITS      = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input beat
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [12:0] i_stored_size,
    input  logic        i_restart,
    // result beat
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_block_number,
    output logic [47:0] o_main_address,
    output logic [47:0] o_main_region,
    output logic [11:0] o_main_offset,
    output logic        o_is_compressed,
    output logic [47:0] o_split_tail_address,
    output logic [47:0] o_split_tail_region,
    output logic [11:0] o_split_tail_offset,
    output logic [11:0] o_split_tail_size,
    output logic [1:0]  o_status,
    output logic        o_table_overflow
);
    localparam int AB = ADDRESS_BITS;
    localparam int XW = (AB > 48) ? AB : 48;
    localparam int IW = (MAX_OPEN_SEGMENTS > 1) ? $clog2(MAX_OPEN_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_OPEN_SEGMENTS + 1);
    localparam int EW = AB + 13;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RST  = 4'd1;
    localparam logic [3:0] S_SIZE = 4'd2;
    localparam logic [3:0] S_SDIV = 4'd3;
    localparam logic [3:0] S_FDIV = 4'd4;
    localparam logic [3:0] S_FCHK = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_TSEL = 4'd7;
    localparam logic [3:0] S_TDIV = 4'd8;
    localparam logic [3:0] S_TCHK = 4'd9;
    localparam logic [3:0] S_COMM = 4'd10;
    localparam logic [3:0] S_REG1 = 4'd11;
    localparam logic [3:0] S_REG2 = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam logic [AB-1:0] TOP = {AB{1'b1}};

    // configuration registers
    logic [47:0] r_base;
    logic [12:0] r_seg_bytes;
    logic [20:0] r_region_bytes;
    logic [12:0] r_logical;

    // sequencer state
    logic [3:0]          r_state;
    tep_pkg::t_size      r_s;
    logic [AB-1:0]       r_cur;
    logic                r_exh;
    logic [31:0]         r_cnt;
    tep_pkg::t_size      r_full;
    tep_pkg::t_size      r_tail;
    logic [AB-1:0]       r_c;
    logic [AB-1:0]       r_main;
    logic [AB-1:0]       r_taddr;
    tep_pkg::t_size      r_toff;
    logic                r_newseg;
    logic [1:0]          r_status;
    logic                r_tovf;
    logic [47:0]         r_mreg;
    logic [47:0]         r_treg;
    logic [MAX_OPEN_SEGMENTS-1:0] r_open;

    // table scan
    logic [CW-1:0]       r_idx;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic                r_best_vld;
    logic [IW-1:0]       r_best;
    tep_pkg::t_size      r_bgap;
    logic [AB-1:0]       r_bbase;
    logic                r_free_vld;
    logic [IW-1:0]       r_free;

    // output register
    logic        r_ovalid;
    logic [31:0] r_o_num;
    logic [47:0] r_o_main;
    logic [47:0] r_o_mreg;
    logic [11:0] r_o_moff;
    logic        r_o_comp;
    logic [47:0] r_o_taddr;
    logic [47:0] r_o_treg;
    logic [11:0] r_o_toff;
    logic [11:0] r_o_tsize;
    logic [1:0]  r_o_status;
    logic        r_o_tovf;

    // divider
    logic          r_div_start;
    logic          n_div_start;
    logic [AB-1:0] r_div_dend;
    logic [20:0]   r_div_sor;
    logic          d_done;
    logic [AB-1:0] d_quot;
    logic [20:0]   d_rem;

    // table RAM
    logic          ram_we;
    logic [EW-1:0] ram_rdata;

    // derived values
    logic [12:0]   seg_eff;
    logic [20:0]   rb_eff;
    logic [AB-1:0] seg_a;
    logic [XW-1:0] base_x;
    logic          base_bad;
    logic [AB-1:0] rem_a;
    logic [AB-1:0] pad;
    logic          align_bad;
    logic [AB-1:0] aligned;
    logic          wr_cfg;
    logic          in_acc;
    logic          out_free;
    logic [AB-1:0] e_base;
    logic [12:0]   e_low;
    logic          e_fit;
    logic [12:0]   e_gap;
    logic          e_open;
    logic [XW-1:0] q_x;
    logic [XW-1:0] main_x;
    logic [XW-1:0] taddr_x;
    logic [XW-1:0] mdiff;
    logic [XW-1:0] tdiff;
    logic [AB-1:0] main_pick;
    logic          has_full;
    logic          has_tail;

    assign seg_eff = (r_seg_bytes == '0) ? 13'd1 :
                     (r_seg_bytes > tep_pkg::SEG_MAX) ? tep_pkg::SEG_MAX : r_seg_bytes;
    assign rb_eff  = (r_region_bytes == '0) ? 21'd1 : r_region_bytes;
    assign seg_a   = AB'(seg_eff);
    assign base_x  = XW'(r_base);
    assign base_bad = base_x > XW'(TOP);

    // align the dividend up from the divider remainder
    assign rem_a     = AB'(d_rem);
    assign pad       = seg_a - rem_a;
    assign align_bad = (d_rem != '0) && (pad > TOP - r_div_dend);
    assign aligned   = (d_rem == '0) ? r_div_dend : r_div_dend + pad;

    assign has_full = r_full != '0;
    assign has_tail = r_tail != '0;

    assign e_base = ram_rdata[EW-1:13];
    assign e_low  = ram_rdata[12:0];
    assign e_open = r_open[r_pidx];
    assign e_fit  = !(e_low > seg_eff) && !(r_tail > seg_eff - e_low);
    assign e_gap  = seg_eff - e_low - r_tail;

    assign main_pick = has_full ? r_main : r_taddr;
    assign q_x     = XW'(d_quot);
    assign main_x  = XW'(main_pick);
    assign taddr_x = XW'(r_taddr);
    assign mdiff   = main_x - base_x;
    assign tdiff   = taddr_x - base_x;

    assign wr_cfg   = psel && penable && pwrite;
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign ram_we   = (r_state == S_COMM) && has_tail && !r_best_vld && r_free_vld;

    tep_div #(.DW(AB), .SW(21)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dend),
        .i_divisor  (r_div_sor),
        .o_done     (d_done),
        .o_quot     (d_quot),
        .o_rem      (d_rem)
    );

    tep_ram #(.W(EW), .D(MAX_OPEN_SEGMENTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free),
        .i_wdata ({r_taddr, r_tail}),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base         <= '0;
            r_seg_bytes    <= 13'd64;
            r_region_bytes <= 21'd4096;
            r_logical      <= 13'd64;
        end else if (wr_cfg) begin
            case (paddr[4:3])
                tep_pkg::REG_BASE:    r_base         <= pwdata[47:0];
                tep_pkg::REG_SEG:     r_seg_bytes    <= pwdata[12:0];
                tep_pkg::REG_REGION:  r_region_bytes <= pwdata[20:0];
                tep_pkg::REG_LOGICAL: r_logical      <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            tep_pkg::REG_BASE:    prdata = 64'(r_base);
            tep_pkg::REG_SEG:     prdata = 64'(r_seg_bytes);
            tep_pkg::REG_REGION:  prdata = 64'(r_region_bytes);
            tep_pkg::REG_LOGICAL: prdata = 64'(r_logical);
            default:              prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // divider launch: one pulse in each state that hands the divider new work
    always_comb begin
        case (r_state)
            S_IDLE:  n_div_start = in_acc && i_restart;
            S_SIZE:  n_div_start = (r_s != '0) && !(r_s > r_logical);
            S_SDIV:  n_div_start = d_done && (r_s != d_rem[12:0]) && !r_exh;
            S_TSEL:  n_div_start = !r_best_vld && !r_exh;
            S_COMM:  n_div_start = 1'b1;
            S_REG1:  n_div_start = d_done && has_full && has_tail;
            default: n_div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= n_div_start;
        end
    end

    // result valid: raise on a finished item, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_exh       <= 1'b0;
            r_cnt       <= '0;
            r_open      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_s       <= i_stored_size;
                        r_status  <= tep_pkg::ST_OK;
                        r_tovf    <= 1'b0;
                        r_newseg  <= 1'b0;
                        r_full    <= '0;
                        r_tail    <= '0;
                        r_best_vld <= 1'b0;
                        if (i_restart) begin
                            // cursor from base aligned up
                            r_div_dend  <= base_x[AB-1:0];
                            r_div_sor   <= 21'(seg_eff);
                            r_state     <= S_RST;
                        end else begin
                            r_state <= S_SIZE;
                        end
                    end
                end
                S_RST: begin
                    if (d_done) begin
                        r_cnt  <= '0;
                        r_open <= '0;
                        if (base_bad || align_bad) begin
                            r_exh <= 1'b1;
                            r_cur <= '0;
                        end else begin
                            r_exh <= 1'b0;
                            r_cur <= aligned;
                        end
                        r_state <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    if (r_s == '0 || r_s > r_logical) begin
                        r_status <= tep_pkg::ST_SIZE;
                        r_state  <= S_OUT;
                    end else begin
                        r_div_dend  <= AB'(r_s);
                        r_div_sor   <= 21'(seg_eff);
                        r_state     <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (d_done) begin
                        r_tail <= d_rem[12:0];
                        r_full <= r_s - d_rem[12:0];
                        r_c    <= r_cur;
                        r_idx  <= '0;
                        r_pv   <= 1'b0;
                        r_free_vld <= 1'b0;
                        if (r_s != d_rem[12:0]) begin
                            if (r_exh) begin
                                r_status <= tep_pkg::ST_OVF;
                                r_state  <= S_OUT;
                            end else begin
                                r_div_dend  <= r_cur;
                                r_state     <= S_FDIV;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FDIV: begin
                    if (d_done) begin
                        if (align_bad) begin
                            r_status <= tep_pkg::ST_OVF;
                            r_state  <= S_OUT;
                        end else begin
                            r_c     <= aligned;
                            r_state <= S_FCHK;
                        end
                    end
                end
                S_FCHK: begin
                    if (AB'(r_full) > TOP - r_c) begin
                        r_status <= tep_pkg::ST_OVF;
                        r_state  <= S_OUT;
                    end else begin
                        r_main  <= r_c;
                        r_c     <= r_c + AB'(r_full);
                        r_state <= has_tail ? S_SCAN : S_COMM;
                    end
                end
                S_SCAN: begin
                    // issue read at r_idx, judge the entry read last cycle
                    if (r_idx != CW'(MAX_OPEN_SEGMENTS)) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pidx <= r_idx[IW-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (!e_open) begin
                            if (!r_free_vld) begin
                                r_free_vld <= 1'b1;
                                r_free     <= r_pidx;
                            end
                        end else if (e_fit && (!r_best_vld || e_gap > r_bgap ||
                                     (e_gap == r_bgap && e_base < r_bbase))) begin
                            r_best_vld <= 1'b1;
                            r_best     <= r_pidx;
                            r_bgap     <= e_gap;
                            r_bbase    <= e_base;
                        end
                    end
                    if (r_idx == CW'(MAX_OPEN_SEGMENTS) && !r_pv) begin
                        r_state <= S_TSEL;
                    end
                end
                S_TSEL: begin
                    if (r_best_vld) begin
                        if (AB'(seg_eff - r_tail) > TOP - r_bbase) begin
                            r_status <= tep_pkg::ST_OVF;
                            r_state  <= S_OUT;
                        end else begin
                            r_toff  <= seg_eff - r_tail;
                            r_taddr <= r_bbase + AB'(seg_eff - r_tail);
                            r_state <= S_COMM;
                        end
                    end else if (r_exh) begin
                        r_status <= tep_pkg::ST_OVF;
                        r_state  <= S_OUT;
                    end else begin
                        r_div_dend  <= r_c;
                        r_div_sor   <= 21'(seg_eff);
                        r_state     <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (d_done) begin
                        if (align_bad) begin
                            r_status <= tep_pkg::ST_OVF;
                            r_state  <= S_OUT;
                        end else begin
                            r_c     <= aligned;
                            r_state <= S_TCHK;
                        end
                    end
                end
                S_TCHK: begin
                    if (seg_a > TOP - r_c) begin
                        r_status <= tep_pkg::ST_OVF;
                        r_state  <= S_OUT;
                    end else begin
                        r_taddr  <= r_c;
                        r_toff   <= '0;
                        r_c      <= r_c + seg_a;
                        r_newseg <= 1'b1;
                        r_state  <= S_COMM;
                    end
                end
                S_COMM: begin
                    if (has_full || r_newseg) begin
                        r_cur <= r_c;
                    end
                    if (has_tail) begin
                        if (r_best_vld) begin
                            r_open[r_best] <= 1'b0;
                        end else if (r_free_vld) begin
                            r_open[r_free] <= 1'b1;
                        end else begin
                            r_tovf <= 1'b1;
                        end
                    end
                    r_div_dend  <= mdiff[AB-1:0];
                    r_div_sor   <= rb_eff;
                    r_state     <= S_REG1;
                end
                S_REG1: begin
                    if (d_done) begin
                        r_mreg <= q_x[47:0];
                        if (has_full && has_tail) begin
                            r_div_dend  <= tdiff[AB-1:0];
                            r_state     <= S_REG2;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_REG2: begin
                    if (d_done) begin
                        r_treg  <= q_x[47:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        if (r_status == tep_pkg::ST_OK) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_num    <= r_cnt;
            r_o_status <= r_status;
            if (r_status == tep_pkg::ST_OK) begin
                r_o_main  <= main_x[47:0];
                r_o_mreg  <= r_mreg;
                r_o_moff  <= has_full ? 12'd0 : r_toff[11:0];
                r_o_comp  <= r_s < r_logical;
                r_o_tovf  <= r_tovf;
                if (has_full && has_tail) begin
                    r_o_taddr <= taddr_x[47:0];
                    r_o_treg  <= r_treg;
                    r_o_toff  <= r_toff[11:0];
                    r_o_tsize <= r_tail[11:0];
                end else begin
                    r_o_taddr <= '0;
                    r_o_treg  <= '0;
                    r_o_toff  <= '0;
                    r_o_tsize <= '0;
                end
            end else begin
                r_o_main  <= '0;
                r_o_mreg  <= '0;
                r_o_moff  <= '0;
                r_o_comp  <= 1'b0;
                r_o_tovf  <= 1'b0;
                r_o_taddr <= '0;
                r_o_treg  <= '0;
                r_o_toff  <= '0;
                r_o_tsize <= '0;
            end
        end
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_ovalid;
    assign o_block_number       = r_o_num;
    assign o_main_address       = r_o_main;
    assign o_main_region        = r_o_mreg;
    assign o_main_offset        = r_o_moff;
    assign o_is_compressed      = r_o_comp;
    assign o_split_tail_address = r_o_taddr;
    assign o_split_tail_region  = r_o_treg;
    assign o_split_tail_offset  = r_o_toff;
    assign o_split_tail_size    = r_o_tsize;
    assign o_status             = r_o_status;
    assign o_table_overflow     = r_o_tovf;

    `TEP_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready, "input taken while busy")
    `TEP_ASSERT_NOW(a_table_write_free, ram_we, !r_open[r_free], "write into an open slot")
    `TEP_ASSERT_NOW(a_fail_zeroes, o_out_valid && o_status != tep_pkg::ST_OK, o_main_address == '0 && o_table_overflow == 1'b0, "failed beat carries data")
endmodule
